// File: rtl/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the spaces-to-tabs packer.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int MAX_TAB_WIDTH = 32;
    localparam int COL_W         = 5;
    localparam int WIDTH_W       = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TAB_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FILL_CHAR = 2'd1;

    localparam logic [WIDTH_W-1:0] DEFAULT_TAB_WIDTH = 6'd8;
    localparam logic [7:0]         DEFAULT_FILL      = 8'd32;
    localparam logic [7:0]         CH_NEWLINE        = 8'd10;
    localparam logic [7:0]         CH_TAB            = 8'd9;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [7:0]         fill;
    } cfg_t;

    // what one input item has to emit: fill_cnt fills, then the main byte
    typedef struct packed {
        logic [COL_W-1:0] fill_cnt;
        logic             has_main;
        logic [7:0]       main_byte;
        logic             last;
    } plan_t;

    typedef struct packed {
        logic busy;
    } emit_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/stp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_cfg_regs
// Tab width and fill character registers, with their effective values.
// ----------------------------------------------------------------------------
module stp_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [stp_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0] wr_data,
    output stp_pkg::cfg_t                 cfg
);
    import stp_pkg::*;

    logic [WIDTH_W-1:0] tab_width_reg, tab_width_next;
    logic [7:0]         fill_char_reg, fill_char_next;

    always_comb begin
        tab_width_next = tab_width_reg;
        fill_char_next = fill_char_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_IDX_TAB_WIDTH: tab_width_next = wr_data[WIDTH_W-1:0];
                CFG_IDX_FILL_CHAR: fill_char_next = wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_width_reg <= DEFAULT_TAB_WIDTH;
            fill_char_reg <= DEFAULT_FILL;
        end else begin
            tab_width_reg <= tab_width_next;
            fill_char_reg <= fill_char_next;
        end
    end

    // zero width means the default, anything past the limit saturates
    always_comb begin
        if (tab_width_reg == '0) begin
            cfg.width = DEFAULT_TAB_WIDTH;
        end else if (tab_width_reg > WIDTH_W'(MAX_TAB_WIDTH)) begin
            cfg.width = WIDTH_W'(MAX_TAB_WIDTH);
        end else begin
            cfg.width = tab_width_reg;
        end
        cfg.fill = (fill_char_reg == 8'd0) ? DEFAULT_FILL : fill_char_reg;
    end

endmodule

// File: rtl/stp_field_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_field_track
// Column and held-fill tracking; turns each item into an emit plan.
// ----------------------------------------------------------------------------
module stp_field_track (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  stp_pkg::cfg_t  cfg,
    output stp_pkg::plan_t plan
);
    import stp_pkg::*;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   held_reg, held_next;
    logic [WIDTH_W-1:0] col0, held0, col_inc, held_inc;
    logic               at_stop;

    always_comb begin
        // width may have shrunk since the last item
        col0     = ({1'b0, col_reg} >= cfg.width) ? '0 : {1'b0, col_reg};
        held0    = ({1'b0, held_reg} > col0) ? col0 : {1'b0, held_reg};
        col_inc  = col0 + WIDTH_W'(1);
        held_inc = held0 + WIDTH_W'(1);
        at_stop  = (col_inc >= cfg.width);

        plan.fill_cnt  = held0[COL_W-1:0];
        plan.has_main  = 1'b1;
        plan.main_byte = in_byte;
        plan.last      = in_last;
        col_next       = '0;
        held_next      = '0;

        if (in_byte == CH_NEWLINE || in_byte == CH_TAB) begin
            col_next = '0;
        end else if (in_byte == cfg.fill) begin
            if (at_stop) begin
                if (held_inc >= WIDTH_W'(2)) begin
                    plan.fill_cnt  = '0;
                    plan.main_byte = CH_TAB;
                end else begin
                    plan.fill_cnt = held_inc[COL_W-1:0];
                    plan.has_main = 1'b0;
                end
            end else begin
                // run continues; a final item flushes it as plain fills
                plan.has_main = 1'b0;
                plan.fill_cnt = in_last ? held_inc[COL_W-1:0] : '0;
                held_next     = held_inc[COL_W-1:0];
                col_next      = col_inc[COL_W-1:0];
            end
        end else begin
            col_next = at_stop ? '0 : col_inc[COL_W-1:0];
        end

        if (in_last) begin
            col_next  = '0;
            held_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            held_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            held_reg <= held_next;
        end
    end

endmodule

// File: rtl/stp_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_emitter
// Sequencer that plays out an emit plan, one output byte per free slot,
// counting the held fills down with a single decrementer.
// ----------------------------------------------------------------------------
module stp_emitter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  stp_pkg::plan_t       plan,
    input  logic [7:0]           fill,
    output stp_pkg::emit_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import stp_pkg::*;

    state_t           state_reg, state_next;
    logic [COL_W-1:0] cnt_reg, cnt_next;
    logic             has_main_reg, has_main_next;
    logic [7:0]       main_reg, main_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             slot_free;
    logic             cnt_one;

    assign slot_free = !m_valid_reg || m_tready;
    assign cnt_one   = (cnt_reg == COL_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (plan.fill_cnt != '0 || plan.has_main)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    if (cnt_reg != '0) begin
                        if (cnt_one && !has_main_reg) state_next = ST_IDLE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        cnt_next      = cnt_reg;
        has_main_next = has_main_reg;
        main_next     = main_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        if (m_tready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next      = plan.fill_cnt;
                    has_main_next = plan.has_main;
                    main_next     = plan.main_byte;
                    last_next     = plan.last;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (cnt_reg != '0) begin
                        m_data_next = fill;
                        m_last_next = last_reg && cnt_one && !has_main_reg;
                        cnt_next    = cnt_reg - COL_W'(1);
                    end else begin
                        m_data_next   = main_reg;
                        m_last_next   = last_reg;
                        has_main_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            has_main_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            has_main_reg <= has_main_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg   <= main_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign status.busy = (state_reg == ST_EMIT);
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign m_tlast     = m_last_reg;

endmodule

// File: rtl/spaces_to_tabs_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spaces_to_tabs_packer_top
// Packs runs of a fill character into tabs, field by field.
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   s_tdata = in_byte, s_tlast = in_last
//   m_       out  m_tvalid/m_tready   m_tdata = out_byte, m_tlast = out_last
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (0 tab_width, 1 fill)
//
// Each accepted item emits N bytes (0 to 32), one per cycle with the output
// free, through the fill down-counter. An item with outputs holds the input
// closed until its last byte is emitted; an item with none leaves it open.
// Output stalls stall the counter. Reset is synchronous, active low, and
// needs no clearing pass.
// ----------------------------------------------------------------------------
module spaces_to_tabs_packer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] in_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import stp_pkg::*;

    cfg_t         cfg;
    plan_t        plan;
    emit_status_t status;
    logic         s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !status.busy;
    assign s_accept  = s_tvalid && s_tready;

    stp_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    stp_field_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .cfg     (cfg),
        .plan    (plan)
    );

    stp_emitter u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .plan     (plan),
        .fill     (cfg.fill),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a final item always has something to flush
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |-> (plan.fill_cnt != '0 || plan.has_main))
        else $error("final item produced no output");

    // newline passes through after any held fills
    a_newline_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tdata == CH_NEWLINE) |->
            (plan.has_main && plan.main_byte == CH_NEWLINE))
        else $error("newline not passed through");

    // an item with output keeps the input closed on the next cycle
    a_busy_after_plan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (plan.fill_cnt != '0 || plan.has_main)) |=> !s_tready)
        else $error("input reopened before output sequence");

    // effective width never leaves its range
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg.width != '0 && cfg.width <= WIDTH_W'(MAX_TAB_WIDTH)))
        else $error("effective tab width out of range");

endmodule
